@@ src/i2cee_pkg.sv @@
// Shared types and constants for the I2C serial memory controller.
// Used by i2cee_cfg, i2cee_seq and the top level; no dependencies.
package i2cee_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] mem_address;
        logic [15:0] byte_count;
        logic [7:0]  write_data;
        logic        write_data_valid;
        logic        sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       write_data_request;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [3:0]  page_size_log2;
        logic [15:0] poll_limit;
    } cfg_t;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_PROBE = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NACK    = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_PAGE_SIZE_LOG2 = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT     = 2'd2;

    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd80;
    localparam logic [3:0]  RST_PAGE_SIZE_LOG2 = 4'd6;
    localparam logic [15:0] RST_POLL_LIMIT     = 16'd1000;

endpackage

@@ src/i2cee_cfg.sv @@
// Configuration register file: device address, page size and poll limit.
// Depends on i2cee_pkg.
module i2cee_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output i2cee_pkg::cfg_t  cfg
);

    i2cee_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= i2cee_pkg::RST_DEVICE_ADDRESS;
            cfg_reg.page_size_log2 <= i2cee_pkg::RST_PAGE_SIZE_LOG2;
            cfg_reg.poll_limit     <= i2cee_pkg::RST_POLL_LIMIT;
        end else if (cfg_wr) begin
            case (cfg_index)
                i2cee_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                i2cee_pkg::REG_PAGE_SIZE_LOG2: cfg_reg.page_size_log2 <= cfg_data[3:0];
                i2cee_pkg::REG_POLL_LIMIT:     cfg_reg.poll_limit     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/i2cee_seq.sv @@
// Bus sequencer: state registers and the per-tick next-state and line logic.
// Depends on i2cee_pkg.
module i2cee_seq #(
    parameter int ADDRESS_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  i2cee_pkg::cfg_t      cfg,
    input  i2cee_pkg::in_item_t  item,
    output i2cee_pkg::out_item_t result
);

    localparam logic [4:0] ST_IDLE         = 5'd0;
    localparam logic [4:0] ST_START        = 5'd1;
    localparam logic [4:0] ST_DEVW_TX      = 5'd2;
    localparam logic [4:0] ST_DEVW_ACK     = 5'd3;
    localparam logic [4:0] ST_AHI_TX       = 5'd4;
    localparam logic [4:0] ST_AHI_ACK      = 5'd5;
    localparam logic [4:0] ST_ALO_TX       = 5'd6;
    localparam logic [4:0] ST_ALO_ACK      = 5'd7;
    localparam logic [4:0] ST_RSTART       = 5'd8;
    localparam logic [4:0] ST_DEVR_TX      = 5'd9;
    localparam logic [4:0] ST_DEVR_ACK     = 5'd10;
    localparam logic [4:0] ST_RD_RX        = 5'd11;
    localparam logic [4:0] ST_RD_ACK       = 5'd12;
    localparam logic [4:0] ST_WR_WAIT      = 5'd13;
    localparam logic [4:0] ST_WR_TX        = 5'd14;
    localparam logic [4:0] ST_WR_ACK       = 5'd15;
    localparam logic [4:0] ST_PRESTOP      = 5'd16;
    localparam logic [4:0] ST_STOP_OK      = 5'd17;
    localparam logic [4:0] ST_STOP_NACK    = 5'd18;
    localparam logic [4:0] ST_STOP_TIMEOUT = 5'd19;

    logic [4:0]              state_reg,   state_next;
    logic [1:0]              phase_reg,   phase_next;
    logic [3:0]              bit_reg,     bit_next;
    logic [7:0]              shift_reg,   shift_next;
    logic [ADDRESS_BITS-1:0] addr_reg,    addr_next;
    logic [15:0]             left_reg,    left_next;
    logic [15:0]             poll_reg,    poll_next;
    logic [1:0]              op_reg,      op_next;

    always_comb begin
        logic        moved;
        logic [1:0]  ph;
        logic        last;
        logic        ack;
        logic [15:0] addr_ext;
        logic [15:0] pmask;
        logic [7:0]  dev;

        state_next = state_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        poll_next  = poll_reg;
        op_next    = op_reg;
        moved      = 1'b0;
        ack        = 1'b0;
        dev        = {cfg.device_address, 1'b0};
        pmask      = (16'd1 << cfg.page_size_log2) - 16'd1;
        result     = '0;
        result.scl     = 1'b1;
        result.sda_out = 1'b1;

        if (state_reg == ST_IDLE && item.command != i2cee_pkg::CMD_NONE) begin
            op_next    = item.command;
            addr_next  = item.mem_address[ADDRESS_BITS-1:0];
            left_next  = item.byte_count;
            poll_next  = '0;
            shift_next = '0;
            phase_next = '0;
            bit_next   = '0;
            if (item.command == i2cee_pkg::CMD_WRITE) begin
                state_next = (item.byte_count != 16'd0) ? ST_PRESTOP : ST_STOP_OK;
            end else begin
                state_next = ST_START;
            end
        end

        addr_ext = 16'(addr_next);
        ph       = (phase_next == 2'd3) ? 2'd2 : phase_next;
        last     = (ph == 2'd2);

        if (state_next != ST_IDLE) begin
            result.busy_res = 1'b1;
            case (state_next)
                ST_START, ST_RSTART: begin
                    result.scl     = (ph != 2'd2);
                    result.sda_out = (ph == 2'd0);
                    if (last) begin
                        moved      = 1'b1;
                        phase_next = '0;
                        bit_next   = '0;
                        if (state_next == ST_START) begin
                            state_next = ST_DEVW_TX;
                            shift_next = dev;
                        end else begin
                            state_next = ST_DEVR_TX;
                            shift_next = dev | 8'd1;
                        end
                    end
                end
                ST_DEVW_TX, ST_AHI_TX, ST_ALO_TX, ST_DEVR_TX, ST_WR_TX: begin
                    result.scl     = (ph == 2'd1);
                    result.sda_out = shift_next[7];
                    if (last) begin
                        shift_next = {shift_next[6:0], 1'b0};
                        bit_next   = bit_next + 4'd1;
                        moved      = 1'b1;
                        phase_next = '0;
                        if (bit_next >= 4'd8) begin
                            state_next = state_next + 5'd1;
                            bit_next   = '0;
                        end
                    end
                end
                ST_DEVW_ACK, ST_AHI_ACK, ST_ALO_ACK, ST_DEVR_ACK, ST_WR_ACK: begin
                    result.scl     = (ph == 2'd1);
                    result.sda_out = 1'b1;
                    if (ph == 2'd1) begin
                        shift_next = {7'd0, item.sda_in};
                    end
                    if (last) begin
                        ack        = ~shift_next[0];
                        moved      = 1'b1;
                        phase_next = '0;
                        bit_next   = '0;
                        case (state_next)
                            ST_DEVW_ACK: begin
                                if (ack) begin
                                    if (op_next == i2cee_pkg::CMD_PROBE) begin
                                        state_next = ST_STOP_OK;
                                    end else if (ADDRESS_BITS > 8) begin
                                        state_next = ST_AHI_TX;
                                        shift_next = addr_ext[15:8];
                                    end else begin
                                        state_next = ST_ALO_TX;
                                        shift_next = addr_ext[7:0];
                                    end
                                end else if (op_next == i2cee_pkg::CMD_WRITE) begin
                                    poll_next  = poll_next + 16'd1;
                                    state_next = (poll_next >= cfg.poll_limit) ?
                                                 ST_STOP_TIMEOUT : ST_START;
                                end else begin
                                    state_next = ST_STOP_NACK;
                                end
                            end
                            ST_AHI_ACK: begin
                                if (ack) begin
                                    state_next = ST_ALO_TX;
                                    shift_next = addr_ext[7:0];
                                end else begin
                                    state_next = ST_STOP_NACK;
                                end
                            end
                            ST_ALO_ACK: begin
                                if (!ack) begin
                                    state_next = ST_STOP_NACK;
                                end else if (op_next == i2cee_pkg::CMD_WRITE) begin
                                    state_next = ST_WR_WAIT;
                                end else begin
                                    state_next = ST_RSTART;
                                end
                            end
                            ST_DEVR_ACK: begin
                                if (!ack) begin
                                    state_next = ST_STOP_NACK;
                                end else if (left_next == 16'd0) begin
                                    state_next = ST_STOP_OK;
                                end else begin
                                    state_next = ST_RD_RX;
                                    shift_next = '0;
                                end
                            end
                            default: begin
                                if (!ack) begin
                                    state_next = ST_STOP_NACK;
                                end else begin
                                    addr_next = addr_next + ADDRESS_BITS'(1);
                                    left_next = left_next - 16'd1;
                                    if (left_next == 16'd0) begin
                                        state_next = ST_STOP_OK;
                                    end else if ((16'(addr_next) & pmask) == 16'd0) begin
                                        poll_next  = '0;
                                        state_next = ST_PRESTOP;
                                    end else begin
                                        state_next = ST_WR_WAIT;
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_RD_RX: begin
                    result.scl     = (ph == 2'd1);
                    result.sda_out = 1'b1;
                    if (ph == 2'd1) begin
                        shift_next = {shift_next[6:0], item.sda_in};
                    end
                    if (last) begin
                        bit_next   = bit_next + 4'd1;
                        moved      = 1'b1;
                        phase_next = '0;
                        if (bit_next >= 4'd8) begin
                            result.read_valid = 1'b1;
                            result.read_data  = shift_next;
                            result.read_last  = (left_next <= 16'd1);
                            state_next        = ST_RD_ACK;
                            bit_next          = '0;
                        end
                    end
                end
                ST_RD_ACK: begin
                    result.scl     = (ph == 2'd1);
                    result.sda_out = (left_next <= 16'd1);
                    if (last) begin
                        left_next  = left_next - 16'd1;
                        addr_next  = addr_next + ADDRESS_BITS'(1);
                        moved      = 1'b1;
                        phase_next = '0;
                        bit_next   = '0;
                        if (left_next == 16'd0) begin
                            state_next = ST_STOP_OK;
                        end else begin
                            state_next = ST_RD_RX;
                            shift_next = '0;
                        end
                    end
                end
                ST_WR_WAIT: begin
                    result.scl                = 1'b0;
                    result.sda_out            = 1'b1;
                    result.write_data_request = 1'b1;
                    moved                     = 1'b1;
                    phase_next                = '0;
                    if (item.write_data_valid) begin
                        state_next = ST_WR_TX;
                        bit_next   = '0;
                        shift_next = item.write_data;
                    end
                end
                ST_PRESTOP, ST_STOP_OK, ST_STOP_NACK, ST_STOP_TIMEOUT: begin
                    result.scl     = (ph != 2'd0);
                    result.sda_out = (ph == 2'd2);
                    if (last) begin
                        moved      = 1'b1;
                        phase_next = '0;
                        bit_next   = '0;
                        if (state_next == ST_PRESTOP) begin
                            state_next = ST_START;
                        end else begin
                            result.done_res = 1'b1;
                            if (state_next == ST_STOP_OK) begin
                                result.status = i2cee_pkg::STAT_OK;
                            end else if (state_next == ST_STOP_NACK) begin
                                result.status = i2cee_pkg::STAT_NACK;
                            end else begin
                                result.status = i2cee_pkg::STAT_TIMEOUT;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                    phase_next = '0;
                    bit_next   = '0;
                    moved      = 1'b1;
                end
            endcase
            if (!moved) begin
                phase_next = phase_next + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
            poll_reg  <= '0;
            op_reg    <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            poll_reg  <= poll_next;
            op_reg    <= op_next;
        end
    end

endmodule

@@ src/i2c_eeprom_master_controller.sv @@
// I2C master for a serial memory with 16-bit word addresses: input and
// result registers around the sequencer. Depends on i2cee_pkg, i2cee_cfg
// and i2cee_seq.
//
// Usage: every transfer on the s_ channel is one bus tick. It carries the
// sampled SDA level and may carry a command (read, write or probe), which
// is taken only while the sequencer is idle. Every tick yields exactly one
// result transfer on the m_ channel with the SCL and SDA levels to drive,
// any completed read byte, the write data request and the done/status flags.
// Write bytes are offered with write_data_valid on a tick that sees the
// request; SCL stays low until one arrives.
// Flow: a tick accepted into the input register passes through the
// sequencer logic and is registered in the result register. Throughput is
// one tick per cycle while the m_ receiver does not stall, set by the single
// pass of sequencer logic between the input register and the result register.
// When the m_ receiver stalls, the result register holds, the input
// register fills, and s_ready drops until the result is taken.
// Reset (synchronous, active low) empties both registers, returns the
// sequencer to idle and restores the configuration defaults. The cfg_
// channel is always ready; write it only while the block is idle.
module i2c_eeprom_master_controller #(
    parameter int ADDRESS_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2cee_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cee_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    i2cee_pkg::in_item_t  in_reg;
    logic                 in_valid_reg;
    i2cee_pkg::out_item_t out_reg;
    logic                 out_valid_reg;
    i2cee_pkg::out_item_t step_result;
    i2cee_pkg::cfg_t      cfg;
    logic                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    i2cee_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cee_seq #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

endmodule
